### design/pra_pkg.sv
// Shared types, constants and the arctangent table for the pose rotate and accumulate block.
package pra_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned STEP_W = 5;
  localparam int unsigned ATAN_ENTRIES = 30;

  localparam int unsigned DW = 32;
  localparam int unsigned OPA_W = 33;
  localparam int unsigned PW = OPA_W + DW;
  localparam int unsigned GUARD = 14;
  localparam int unsigned XW = 48;
  localparam int unsigned RW = XW - GUARD;
  localparam int unsigned ZW = 34;

  localparam logic signed [DW-1:0] GAIN_Q31  = 32'sd1304065748;
  localparam logic signed [DW-1:0] RAD_TO_BA = 32'sd683565276;
  localparam logic signed [DW-1:0] DEG_TO_BA = 32'sd11930465;

  typedef enum logic [2:0] {
    ACT_MOVE_GLOBAL = 3'd0,
    ACT_MOVE_LOCAL  = 3'd1,
    ACT_ROT_RAD     = 3'd2,
    ACT_ROT_DEG     = 3'd3,
    ACT_SET_POS     = 3'd4,
    ACT_SET_HEADING = 3'd5
  } action_e;

  typedef struct packed {
    logic              load_x;
    logic              load_y;
    logic              step;
    logic [STEP_W-1:0] idx;
  } rot_ctrl_t;

  function automatic logic [DW-1:0] atan_ba(input logic [STEP_W-1:0] idx);
    logic [DW-1:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      5'd24:   r = 32'h00000029;
      5'd25:   r = 32'h00000014;
      5'd26:   r = 32'h0000000A;
      5'd27:   r = 32'h00000005;
      5'd28:   r = 32'h00000003;
      5'd29:   r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### design/pra_mul.sv
// Shared signed multiplier with a registered product.
module pra_mul (
  input  logic                             clk_i,
  input  logic signed [pra_pkg::OPA_W-1:0] op_a_i,
  input  logic signed [pra_pkg::DW-1:0]    op_b_i,
  output logic signed [pra_pkg::PW-1:0]    prod_o
);
  import pra_pkg::*;

  logic signed [PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(op_a_i) * PW'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

### design/pra_rot.sv
// CORDIC rotation datapath: prescale load and one micro-rotation per cycle.
module pra_rot (
  input  logic                          clk_i,
  input  pra_pkg::rot_ctrl_t            ctrl_i,
  input  logic signed [pra_pkg::PW-1:0] prod_i,
  input  logic [pra_pkg::DW-1:0]        z_init_i,
  output logic signed [pra_pkg::RW-1:0] rx_o,
  output logic signed [pra_pkg::RW-1:0] ry_o
);
  import pra_pkg::*;

  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic signed [PW-1:0] prod_rnd;
  logic signed [XW-1:0] pre;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  logic signed [XW-1:0] x_rnd, y_rnd;

  always_comb begin
    prod_rnd = prod_i + PW'(65536);
    pre      = prod_rnd[XW+16:17];
    dx       = y_q >>> ctrl_i.idx;
    dy       = x_q >>> ctrl_i.idx;
    at       = ZW'(atan_ba(ctrl_i.idx));
    x_rnd    = x_q + XW'(8192);
    y_rnd    = y_q + XW'(8192);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_x) begin
      x_q <= pre;
    end
    if (ctrl_i.load_y) begin
      y_q <= pre;
      z_q <= ZW'($signed(z_init_i));
    end
    if (ctrl_i.step) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign rx_o = x_rnd[XW-1:GUARD];
  assign ry_o = y_rnd[XW-1:GUARD];

endmodule

### design/pose_rotate_and_accumulate_core.sv
// Top level: sequencer, pose registers and handshakes of the pose rotate and accumulate block.
// Keeps a Q16.16 position and a 32-bit binary-angle heading and returns the pose after every
// request. One request is in flight at a time; in_stall_o is high from acceptance until the
// result is registered. A local move runs ST_MUL_X and ST_MUL_Y (two multiplier passes for the
// gain prescale), ST_LOAD_Y (one load), ST_ROT (CORDIC_STEPS passes through the iterative
// micro-rotation unit) and ST_DONE (one accumulate). Angle requests run ST_MUL_A (one multiplier
// pass), ST_ANG (one heading update) and ST_DONE (one write-back); global moves, position sets
// and unknown actions go straight to ST_DONE. Position sums saturate, the heading wraps.
module pose_rotate_and_accumulate_core #(
  parameter int unsigned CORDIC_STEPS = pra_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    action_i,
  input  logic signed [pra_pkg::DW-1:0] vec_x_i,
  input  logic signed [pra_pkg::DW-1:0] vec_y_i,
  input  logic signed [pra_pkg::DW-1:0] angle_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [pra_pkg::DW-1:0] pos_x_o,
  output logic signed [pra_pkg::DW-1:0] pos_y_o,
  output logic [pra_pkg::DW-1:0]        heading_o
);
  import pra_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_LOAD_Y,
    ST_ROT,
    ST_MUL_A,
    ST_ANG,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [STEP_W-1:0]    step_q;
  logic                 out_valid_q;
  logic [2:0]           action_q;
  logic signed [DW-1:0] vec_x_q, vec_y_q, angle_q;
  logic signed [DW-1:0] cur_x_q, cur_y_q;
  logic [DW-1:0]        cur_head_q, head_new_q;

  logic                    accept, out_free, fold;
  logic signed [OPA_W-1:0] op_a;
  logic signed [DW-1:0]    op_b;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    prod_rnd;
  logic [DW-1:0]           ba;
  logic [DW-1:0]           z_init;
  rot_ctrl_t               rot_ctrl;
  logic signed [RW-1:0]    rx, ry;
  logic signed [RW-1:0]    mx, my;
  logic signed [RW:0]      sum_x, sum_y;
  logic signed [DW-1:0]    sat_x, sat_y;

  function automatic logic signed [DW-1:0] sat(input logic signed [RW:0] v);
    logic signed [DW-1:0] r;
    if ((v[RW:DW-1] == '0) || (v[RW:DW-1] == '1)) begin
      r = v[DW-1:0];
    end else if (v[RW]) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign fold     = cur_head_q[DW-1] ^ cur_head_q[DW-2];
  assign z_init   = fold ? {~cur_head_q[DW-1], cur_head_q[DW-2:0]} : cur_head_q;

  always_comb begin
    op_a = OPA_W'(angle_q);
    op_b = RAD_TO_BA;
    unique case (state_q)
      ST_MUL_X: begin
        op_a = fold ? -OPA_W'(vec_x_q) : OPA_W'(vec_x_q);
        op_b = GAIN_Q31;
      end
      ST_MUL_Y: begin
        op_a = fold ? -OPA_W'(vec_y_q) : OPA_W'(vec_y_q);
        op_b = GAIN_Q31;
      end
      ST_MUL_A: begin
        op_b = (action_q == ACT_ROT_DEG) ? DEG_TO_BA : RAD_TO_BA;
      end
      default: begin
      end
    endcase
  end

  pra_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  always_comb begin
    rot_ctrl.load_x = (state_q == ST_MUL_Y);
    rot_ctrl.load_y = (state_q == ST_LOAD_Y);
    rot_ctrl.step   = (state_q == ST_ROT);
    rot_ctrl.idx    = step_q;
  end

  pra_rot u_rot (
    .clk_i    (clk_i),
    .ctrl_i   (rot_ctrl),
    .prod_i   (prod),
    .z_init_i (z_init),
    .rx_o     (rx),
    .ry_o     (ry)
  );

  always_comb begin
    prod_rnd = prod + PW'(32768);
    ba       = prod_rnd[DW+15:16];
    mx       = (action_q == ACT_MOVE_LOCAL) ? rx : RW'(vec_x_q);
    my       = (action_q == ACT_MOVE_LOCAL) ? ry : RW'(vec_y_q);
    sum_x    = (RW+1)'(cur_x_q) + (RW+1)'(mx);
    sum_y    = (RW+1)'(cur_y_q) + (RW+1)'(my);
    sat_x    = sat(sum_x);
    sat_y    = sat(sum_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_head_q  <= '0;
    end else begin
      out_valid_q <= (out_valid_q && out_stall_i) || ((state_q == ST_DONE) && out_free);
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (action_e'(action_i))
              ACT_MOVE_LOCAL:                          state_q <= ST_MUL_X;
              ACT_ROT_RAD, ACT_ROT_DEG, ACT_SET_HEADING: state_q <= ST_MUL_A;
              default:                                 state_q <= ST_DONE;
            endcase
          end
        end
        ST_MUL_X:  state_q <= ST_MUL_Y;
        ST_MUL_Y:  state_q <= ST_LOAD_Y;
        ST_LOAD_Y: begin
          step_q  <= '0;
          state_q <= ST_ROT;
        end
        ST_ROT: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_MUL_A:  state_q <= ST_ANG;
        ST_ANG:    state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            unique case (action_e'(action_q))
              ACT_MOVE_GLOBAL, ACT_MOVE_LOCAL: begin
                cur_x_q <= sat_x;
                cur_y_q <= sat_y;
              end
              ACT_SET_POS: begin
                cur_x_q <= vec_x_q;
                cur_y_q <= vec_y_q;
              end
              ACT_ROT_RAD, ACT_ROT_DEG, ACT_SET_HEADING: begin
                cur_head_q <= head_new_q;
              end
              default: begin
              end
            endcase
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      vec_x_q  <= vec_x_i;
      vec_y_q  <= vec_y_i;
      angle_q  <= angle_in_i;
    end
    if (state_q == ST_ANG) begin
      head_new_q <= (action_q == ACT_SET_HEADING) ? ba : cur_head_q + ba;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign pos_x_o     = cur_x_q;
  assign pos_y_o     = cur_y_q;
  assign heading_o   = cur_head_q;

endmodule
